// File: hw/rtl/lps_pkg.sv
// Shared types and constants of the lottery process scheduler.
`default_nettype none
package lps_pkg;
  localparam int SlotsDefault = 64;
  localparam int RndW         = 32;
  localparam int InW          = 72;
  localparam int OutW         = 48;

  localparam logic [2:0] ACT_START   = 3'd0;
  localparam logic [2:0] ACT_STOP    = 3'd1;
  localparam logic [2:0] ACT_QUANTUM = 3'd2;
  localparam logic [2:0] ACT_NICE    = 3'd3;
  localparam logic [2:0] ACT_BALANCE = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADSLOT = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [3:0] Q_LOSER  = 4'd15;
  localparam logic [3:0] Q_WINNER = 4'd14;
  localparam logic [3:0] Q_BLOCK  = 4'd13;
  localparam logic [3:0] Q_FLOOR  = 4'd12;

  localparam logic [11:0] START_TICKETS = 12'd20;
  localparam logic [11:0] TICKET_MAX    = 12'd4095;
  localparam int          NiceLimit     = 100;
  localparam int          NiceBias      = 20;
  localparam int          PrioLevels    = 16;

  typedef struct packed {
    logic [15:0] wins;
    logic [15:0] slice;
    logic [11:0] tickets;
    logic [3:0]  max_prio;
    logic [3:0]  prio;
  } slot_entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_START_WR,
    S_RMW_WR,
    S_BAL,
    S_DRAW1,
    S_DIV,
    S_DRAW2,
    S_REP_RD,
    S_REP
  } state_e;
endpackage
`default_nettype wire

// File: hw/rtl/lottery_process_scheduler_top.sv
// Lottery process scheduler: slot table in memory with a sequencer for actions and draws.
//
// Usage: one request transaction enters on the s_axis channel (tdata holds action, slot,
// parent slot, inherit, level, quantum and the random value) and exactly one result
// transaction leaves on the m_axis channel (status, winner flag, winner slot and the
// addressed slot's priority, tickets and time slice).
// Slot records live in one synchronous memory (one read and one write port, read data
// registered); use flags are flip-flops cleared at reset, so the block is ready right
// after reset with every slot free.
// Each pass over the table runs through the memory read port, and the modulo of the random
// value by the loser ticket total runs one bit per cycle. A draw pass ends early once the
// winner is found.
// The block works on one request at a time; a new request is taken as soon as the
// previous result sits in the output register, even if the receiver has not taken it.
// When the receiver stalls, the result holds in the output register and a following
// request waits in its final stage until the register frees up.
`default_nettype none
module lottery_process_scheduler_top #(
  parameter int SLOTS = lps_pkg::SlotsDefault
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // action[2:0], slot[8:3], parent_slot[14:9], inherit[15], level[23:16],
  // quantum[39:24], random_value[71:40]
  input  wire  [lps_pkg::InW-1:0]  s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  wire                      m_axis_tready_i,
  // status[1:0], winner_valid[2], winner_slot[8:3], slot_priority[12:9],
  // slot_tickets[24:13], slot_time_slice[40:25], zero fill[47:41]
  output logic [lps_pkg::OutW-1:0] m_axis_tdata_o
);
  localparam int IW = $clog2(SLOTS);
  localparam int CW = IW + 1;
  localparam int SW = $clog2(SLOTS * 4095 + 1);
  localparam int DCW = $clog2(lps_pkg::RndW);

  // Request fields
  logic [2:0]             act_q;
  logic [5:0]             slot_q, par_q;
  logic                   inh_q;
  logic signed [7:0]      lvl_q;
  logic [15:0]            quant_q;
  logic [lps_pkg::RndW-1:0] rnd_q, rnd_d;

  lps_pkg::state_e state_q, state_d;

  // Slot table
  lps_pkg::slot_entry_t mem [SLOTS];
  lps_pkg::slot_entry_t rd_q, mem_wdata;
  logic                 mem_we;
  logic [IW-1:0]        mem_waddr, mem_raddr;
  logic [SLOTS-1:0]     use_q, use_d;

  // Sweep and draw
  logic [CW-1:0] idx_q, idx_d;
  logic [IW-1:0] pidx_q, pidx_d;
  logic          pv_q, pv_d;
  logic          any_win_q, any_win_d;
  logic [SW-1:0] total_q, total_d, sum_q, sum_d, rem_q, rem_d;
  logic [SW:0]   target_q, target_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;

  // Result
  logic [1:0]    status_q, status_d;
  logic          wv_q, wv_d;
  logic [5:0]    ws_q, ws_d;
  logic          out_v_q, out_v_d;
  logic [40:0]   out_q, out_d;

  logic [IW-1:0] s_idx, p_idx;
  logic          ok_slot, p_ok, s_used, lvl_ok, nice_ok;
  logic [1:0]    dec_status;
  logic          pu, sweep_done, d2_hit, s_accept, out_free;
  logic [SW-1:0] sum_n;
  logic [SW:0]   div_sh;
  logic [SW-1:0] rem_n;
  logic [11:0]   tk2;
  logic [3:0]    q_prio;

  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == lps_pkg::S_IDLE);
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {7'd0, out_q};
  assign out_free = !out_v_q || m_axis_tready_i;

  assign s_idx   = IW'(slot_q);
  assign p_idx   = IW'(par_q);
  assign ok_slot = {26'd0, slot_q} < 32'(SLOTS);
  assign p_ok    = ({26'd0, par_q} < 32'(SLOTS)) && use_q[p_idx];
  assign s_used  = use_q[s_idx];
  assign lvl_ok  = (lvl_q >= 8'sd0) && (lvl_q < 8'(lps_pkg::PrioLevels));
  assign nice_ok = (lvl_q >= -8'(lps_pkg::NiceBias))
                && (lvl_q < 8'(lps_pkg::NiceLimit - lps_pkg::NiceBias));

  assign pu         = use_q[pidx_q];
  assign sweep_done = (idx_q == CW'(SLOTS)) && !pv_q;
  assign sum_n      = sum_q + SW'(rd_q.tickets);
  assign d2_hit     = pv_q && pu && (rd_q.prio == lps_pkg::Q_LOSER)
                   && (target_q <= {1'b0, sum_n});
  assign div_sh     = {rem_q, rnd_q[lps_pkg::RndW-1]};
  assign rem_n      = (div_sh >= {1'b0, total_q}) ? SW'(div_sh - {1'b0, total_q})
                                                  : SW'(div_sh);
  assign tk2        = rd_q.tickets[11] ? lps_pkg::TICKET_MAX : {rd_q.tickets[10:0], 1'b0};

  // Decode the request into a status
  always_comb begin
    dec_status = lps_pkg::ST_OK;
    if (act_q > lps_pkg::ACT_BALANCE) begin
      dec_status = lps_pkg::ST_INVALID;
    end else if (!ok_slot) begin
      dec_status = lps_pkg::ST_BADSLOT;
    end else if (act_q == lps_pkg::ACT_START) begin
      if (s_used) dec_status = lps_pkg::ST_BADSLOT;
      else if (!lvl_ok) dec_status = lps_pkg::ST_INVALID;
      else if (inh_q && !p_ok) dec_status = lps_pkg::ST_BADSLOT;
    end else if (act_q == lps_pkg::ACT_BALANCE) begin
      dec_status = lps_pkg::ST_OK;
    end else if (!s_used) begin
      dec_status = lps_pkg::ST_BADSLOT;
    end else if (act_q == lps_pkg::ACT_NICE && !nice_ok) begin
      dec_status = lps_pkg::ST_INVALID;
    end
  end

  // Quantum expiry: winners and blocked slots rejoin the losers, low queues drop one level
  always_comb begin
    q_prio = rd_q.prio;
    if (rd_q.prio == lps_pkg::Q_WINNER || rd_q.prio == lps_pkg::Q_BLOCK) q_prio = lps_pkg::Q_LOSER;
    if (q_prio < lps_pkg::Q_FLOOR) q_prio = q_prio + 4'd1;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lps_pkg::S_IDLE: if (s_accept) state_d = lps_pkg::S_DEC;
      lps_pkg::S_DEC: begin
        if (dec_status != lps_pkg::ST_OK) begin
          state_d = lps_pkg::S_REP_RD;
        end else begin
          case (act_q)
            lps_pkg::ACT_START:   state_d = lps_pkg::S_START_WR;
            lps_pkg::ACT_QUANTUM,
            lps_pkg::ACT_NICE:    state_d = lps_pkg::S_RMW_WR;
            lps_pkg::ACT_BALANCE: state_d = lps_pkg::S_BAL;
            default:              state_d = lps_pkg::S_REP_RD;
          endcase
        end
      end
      lps_pkg::S_START_WR: state_d = lps_pkg::S_REP_RD;
      lps_pkg::S_RMW_WR:
        state_d = (act_q == lps_pkg::ACT_QUANTUM) ? lps_pkg::S_DRAW1 : lps_pkg::S_REP_RD;
      lps_pkg::S_BAL: if (sweep_done) state_d = any_win_q ? lps_pkg::S_REP_RD : lps_pkg::S_DRAW1;
      lps_pkg::S_DRAW1: if (sweep_done) state_d = (total_q == '0) ? lps_pkg::S_DRAW2
                                                                   : lps_pkg::S_DIV;
      lps_pkg::S_DIV: if (dcnt_q == DCW'(lps_pkg::RndW - 1)) state_d = lps_pkg::S_DRAW2;
      lps_pkg::S_DRAW2: if (d2_hit || sweep_done) state_d = lps_pkg::S_REP_RD;
      lps_pkg::S_REP_RD: state_d = lps_pkg::S_REP;
      lps_pkg::S_REP: if (out_free) state_d = lps_pkg::S_IDLE;
      default: state_d = lps_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    use_d     = use_q;
    idx_d     = idx_q;
    pidx_d    = pidx_q;
    pv_d      = 1'b0;
    any_win_d = any_win_q;
    total_d   = total_q;
    sum_d     = sum_q;
    rem_d     = rem_q;
    target_d  = target_q;
    dcnt_d    = dcnt_q;
    rnd_d     = rnd_q;
    status_d  = status_q;
    wv_d      = wv_q;
    ws_d      = ws_q;
    out_d     = out_q;
    out_v_d   = out_v_q && !m_axis_tready_i;
    mem_we    = 1'b0;
    mem_waddr = pidx_q;
    mem_wdata = rd_q;
    mem_raddr = s_idx;
    if (s_accept) rnd_d = s_axis_tdata_i[71:40];
    case (state_q)
      lps_pkg::S_DEC: begin
        status_d  = dec_status;
        wv_d      = 1'b0;
        ws_d      = '0;
        idx_d     = '0;
        any_win_d = 1'b0;
        total_d   = '0;
        if (act_q == lps_pkg::ACT_START) mem_raddr = p_idx;
        if (dec_status == lps_pkg::ST_OK && act_q == lps_pkg::ACT_STOP) use_d[s_idx] = 1'b0;
      end
      lps_pkg::S_START_WR: begin
        mem_we            = 1'b1;
        mem_waddr         = s_idx;
        mem_wdata.prio    = lps_pkg::Q_LOSER;
        mem_wdata.max_prio = lvl_q[3:0];
        mem_wdata.tickets = lps_pkg::START_TICKETS;
        mem_wdata.wins    = '0;
        mem_wdata.slice   = inh_q ? rd_q.slice : quant_q;
        use_d[s_idx]      = 1'b1;
      end
      lps_pkg::S_RMW_WR: begin
        mem_we    = 1'b1;
        mem_waddr = s_idx;
        if (act_q == lps_pkg::ACT_QUANTUM) begin
          mem_wdata.prio = q_prio;
          if (rd_q.prio == lps_pkg::Q_WINNER || rd_q.prio == lps_pkg::Q_BLOCK)
            mem_wdata.tickets = {1'b0, rd_q.tickets[11:1]};
        end else begin
          mem_wdata.tickets = 12'(lvl_q + 8'(lps_pkg::NiceBias));
        end
      end
      lps_pkg::S_BAL, lps_pkg::S_DRAW1, lps_pkg::S_DRAW2: begin
        // Read one slot ahead while the previous one is processed
        mem_raddr = idx_q[IW-1:0];
        if (idx_q != CW'(SLOTS)) begin
          pidx_d = idx_q[IW-1:0];
          pv_d   = 1'b1;
          idx_d  = idx_q + CW'(1);
        end
        if (state_q == lps_pkg::S_BAL && pv_q && pu) begin
          if (rd_q.prio == lps_pkg::Q_WINNER) any_win_d = 1'b1;
          if (rd_q.prio > rd_q.max_prio && rd_q.prio < lps_pkg::Q_BLOCK) begin
            mem_we         = 1'b1;
            mem_wdata.prio = rd_q.prio - 4'd1;
          end
        end
        if (state_q == lps_pkg::S_DRAW1 && pv_q && pu) begin
          if (rd_q.prio == lps_pkg::Q_LOSER) total_d = total_q + SW'(rd_q.tickets);
          if (rd_q.prio == lps_pkg::Q_WINNER) begin
            mem_we            = 1'b1;
            mem_wdata.prio    = lps_pkg::Q_BLOCK;
            mem_wdata.tickets = tk2;
          end
        end
        if (state_q == lps_pkg::S_DRAW2 && pv_q && pu && rd_q.prio == lps_pkg::Q_LOSER) begin
          sum_d = sum_n;
          if (d2_hit) begin
            mem_we         = 1'b1;
            mem_wdata.prio = lps_pkg::Q_WINNER;
            mem_wdata.wins = rd_q.wins + 16'd1;
            wv_d           = 1'b1;
            ws_d           = 6'(pidx_q);
          end
        end
        if (state_q == lps_pkg::S_BAL && sweep_done) begin
          idx_d   = '0;
          total_d = '0;
        end
        if (state_q == lps_pkg::S_DRAW1 && sweep_done) begin
          idx_d    = '0;
          sum_d    = '0;
          rem_d    = '0;
          dcnt_d   = '0;
          target_d = '0;
        end
      end
      lps_pkg::S_DIV: begin
        rem_d  = rem_n;
        rnd_d  = {rnd_q[lps_pkg::RndW-2:0], 1'b0};
        dcnt_d = dcnt_q + DCW'(1);
        if (dcnt_q == DCW'(lps_pkg::RndW - 1)) target_d = {1'b0, rem_n} + (SW+1)'(1);
      end
      lps_pkg::S_REP: begin
        if (out_free) begin
          out_v_d = 1'b1;
          if (ok_slot && s_used) out_d = {rd_q.slice, rd_q.tickets, rd_q.prio, ws_q, wv_q, status_q};
          else                   out_d = {16'd0, 12'd0, 4'd0, ws_q, wv_q, status_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lps_pkg::S_IDLE;
      use_q   <= '0;
      out_v_q <= 1'b0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      use_q   <= use_d;
      out_v_q <= out_v_d;
      pv_q    <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      act_q   <= s_axis_tdata_i[2:0];
      slot_q  <= s_axis_tdata_i[8:3];
      par_q   <= s_axis_tdata_i[14:9];
      inh_q   <= s_axis_tdata_i[15];
      lvl_q   <= s_axis_tdata_i[23:16];
      quant_q <= s_axis_tdata_i[39:24];
    end
    rnd_q     <= rnd_d;
    idx_q     <= idx_d;
    pidx_q    <= pidx_d;
    any_win_q <= any_win_d;
    total_q   <= total_d;
    sum_q     <= sum_d;
    rem_q     <= rem_d;
    target_q  <= target_d;
    dcnt_q    <= dcnt_d;
    status_q  <= status_d;
    wv_q      <= wv_d;
    ws_q      <= ws_d;
    out_q     <= out_d;
  end

  // Slot table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_q <= mem[mem_raddr];
  end

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lps_pkg::S_IDLE |-> !mem_we) else $error("table write while idle");
  a_target_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lps_pkg::S_DRAW2 && total_q != '0) |-> (target_q <= {1'b0, total_q}))
    else $error("draw target above ticket total");
  a_accept_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> state_q == lps_pkg::S_DEC) else $error("accepted request not decoded");
  a_win_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lps_pkg::S_REP && wv_q) |->
      (act_q == lps_pkg::ACT_QUANTUM || act_q == lps_pkg::ACT_BALANCE))
    else $error("winner without draw");
endmodule
`default_nettype wire
